// ----- sv/ght_pkg.sv -----
// Package for the grouped handle table: sizes, operation and status codes,
// and the operand/result records of the shared group-scan unit.
// No dependencies.
package ght_pkg;

    localparam int HANDLES  = 64;
    localparam int GROUPS   = 16;
    localparam int HW       = 6;   // handle and position width
    localparam int GW       = 4;   // group index width
    localparam int SW       = 7;   // group size / running sum width
    localparam int KW       = 32;  // group key width

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_SPARE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_HMAP_FULL  = 2'd1,
        ST_GROUP_FULL = 2'd2,
        ST_BAD_HANDLE = 2'd3
    } t_status;

    // Operands of one group-scan step
    typedef struct packed {
        logic [SW-1:0] acc;     // start position of the group
        logic [SW-1:0] size;    // size of the group
        logic [HW-1:0] pos;     // position being located
        logic [KW-1:0] key_a;   // stored key of the group
        logic [KW-1:0] key_b;   // key being searched
    } t_alu_in;

    typedef struct packed {
        logic [SW-1:0] sum;     // start of the next group
        logic          in_range;
        logic          key_eq;
    } t_alu_out;

endpackage

// ----- sv/grouped_handle_table_unit.sv -----
// Grouped handle table: top level with sequencer, handle state and
// position memory. Depends on ght_pkg and ght_alu.
//
// One transaction is worked on at a time; o_stall is high from acceptance
// until the result has been taken. The time a transaction takes is set by
// the scan for the lowest free handle on add, by the walk over the group
// table through one shared adder/compare unit, and, for add and remove, by
// the walk over the 64-entry position memory, one entry per cycle on its
// single read and write port.
module grouped_handle_table_unit import ght_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [1:0]    i_kind,
    input  logic [KW-1:0] i_group_key,
    input  logic [HW-1:0] i_handle_in,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [1:0]    o_status,
    output logic [HW-1:0] o_handle_out,
    output logic [HW-1:0] o_position,
    output logic [HW-1:0] o_move_count,
    output logic [GW-1:0] o_group_slot,
    output logic          o_any_entries
);

    typedef enum logic [3:0] {
        S_IDLE, S_HSCAN, S_HREAD, S_GSCAN, S_GDECIDE,
        S_GSHIFT, S_SWEEP, S_FINISH, S_OUT
    } t_state;

    t_state         r_state;
    t_kind          r_kind;
    t_status        r_status;
    logic [KW-1:0]  r_key;
    logic [HW-1:0]  r_hin;
    logic [HW-1:0]  r_h;
    logic [HW-1:0]  r_hout;
    logic [HW:0]    r_i;
    logic [GW:0]    r_g;
    logic [GW:0]    r_total;
    logic [SW-1:0]  r_acc;
    logic           r_found;
    logic [GW-1:0]  r_slot;
    logic [SW-1:0]  r_slot_size;
    logic [HW-1:0]  r_pos;
    logic [HW-1:0]  r_moves;
    logic           r_valid;
    logic [HANDLES-1:0] r_used;
    logic [KW-1:0]  r_keys  [GROUPS];
    logic [SW-1:0]  r_sizes [GROUPS];

    // Position memory
    logic [HW-1:0]  r_hpos_mem [HANDLES];
    logic [HW-1:0]  r_hpos_rd;

    logic [GW:0]    w_gnext;
    logic [GW-1:0]  w_gidx;
    logic [HW:0]    w_prev;
    logic [HW-1:0]  w_entry;
    logic           w_hit;
    logic [HW-1:0]  w_rd_addr;
    logic           w_we;
    logic [HW-1:0]  w_waddr;
    logic [HW-1:0]  w_wdata;
    logic           w_is_add;
    t_alu_in        w_alu_in;
    t_alu_out       w_alu_out;

    ght_alu u_alu (
        .i_op  (w_alu_in),
        .o_res (w_alu_out)
    );

    // Group table read index: shift reads one slot above the write
    always_comb begin
        w_gnext  = r_g + 1'b1;
        w_gidx   = (r_state == S_GSHIFT) ? w_gnext[GW-1:0] : r_g[GW-1:0];
        w_is_add = (r_kind == KIND_ADD);
        w_alu_in.acc   = r_acc;
        w_alu_in.size  = r_sizes[w_gidx];
        w_alu_in.pos   = r_pos;
        w_alu_in.key_a = r_keys[w_gidx];
        w_alu_in.key_b = r_key;
    end

    // Position sweep: read entry i, update entry i-1 from last read data
    always_comb begin
        w_prev    = r_i - 1'b1;
        w_entry   = w_prev[HW-1:0];
        w_hit     = r_used[w_entry] &&
                    (w_is_add ? (r_hpos_rd >= r_pos) : (r_hpos_rd > r_pos));
        w_rd_addr = (r_state == S_IDLE) ? i_handle_in : r_i[HW-1:0];
        w_we      = 1'b0;
        w_waddr   = w_entry;
        w_wdata   = w_is_add ? r_hpos_rd + 1'b1 : r_hpos_rd - 1'b1;
        if (r_state == S_SWEEP && r_i != '0 && w_hit) begin
            w_we = 1'b1;
        end else if (r_state == S_FINISH) begin
            w_we    = 1'b1;
            w_waddr = r_h;
            w_wdata = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_hpos_mem[w_waddr] <= w_wdata;
        end
        r_hpos_rd <= r_hpos_mem[w_rd_addr];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_used  <= '0;
            r_total <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind  <= t_kind'(i_kind);
                        r_key   <= i_group_key;
                        r_hin   <= i_handle_in;
                        r_i     <= '0;
                        r_g     <= '0;
                        r_acc   <= '0;
                        r_found <= 1'b0;
                        if (t_kind'(i_kind) == KIND_ADD) begin
                            r_state <= S_HSCAN;
                        end else if (!r_used[i_handle_in]) begin
                            r_status <= ST_BAD_HANDLE;
                            r_hout   <= i_handle_in;
                            r_pos    <= '0;
                            r_moves  <= '0;
                            r_slot   <= '0;
                            r_valid  <= 1'b1;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_HREAD;
                        end
                    end
                end
                // lowest free handle, one per cycle
                S_HSCAN: begin
                    if (!r_used[r_i[HW-1:0]]) begin
                        r_h     <= r_i[HW-1:0];
                        r_state <= S_GSCAN;
                    end else if (r_i == (HW+1)'(HANDLES - 1)) begin
                        r_status <= ST_HMAP_FULL;
                        r_hout   <= '0;
                        r_pos    <= '0;
                        r_moves  <= '0;
                        r_slot   <= '0;
                        r_valid  <= 1'b1;
                        r_state  <= S_OUT;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_HREAD: begin
                    r_pos   <= r_hpos_rd;
                    r_state <= S_GSCAN;
                end
                // walk groups: key match for add, range match otherwise
                S_GSCAN: begin
                    if (r_g == r_total) begin
                        r_state <= S_GDECIDE;
                    end else begin
                        r_acc <= w_alu_out.sum;
                        r_g   <= w_gnext;
                        if (!r_found) begin
                            if (w_is_add && w_alu_out.key_eq) begin
                                r_found     <= 1'b1;
                                r_slot      <= r_g[GW-1:0];
                                r_slot_size <= w_alu_in.size;
                                r_pos       <= w_alu_out.sum[HW-1:0];
                            end else if (!w_is_add && w_alu_out.in_range) begin
                                r_found     <= 1'b1;
                                r_slot      <= r_g[GW-1:0];
                                r_slot_size <= w_alu_in.size;
                            end
                        end
                    end
                end
                S_GDECIDE: begin
                    r_i <= '0;
                    if (w_is_add) begin
                        if (!r_found && r_total == (GW+1)'(GROUPS)) begin
                            r_status <= ST_GROUP_FULL;
                            r_hout   <= '0;
                            r_pos    <= '0;
                            r_moves  <= '0;
                            r_slot   <= '0;
                            r_valid  <= 1'b1;
                            r_state  <= S_OUT;
                        end else if (r_found) begin
                            r_hout   <= r_h;
                            r_status <= ST_OK;
                            r_sizes[r_slot] <= r_slot_size + 1'b1;
                            r_moves <= r_acc[HW-1:0] - r_pos;
                            r_state <= S_SWEEP;
                        end else begin
                            r_hout   <= r_h;
                            r_status <= ST_OK;
                            r_keys[r_total[GW-1:0]]  <= r_key;
                            r_sizes[r_total[GW-1:0]] <= SW'(1);
                            r_slot  <= r_total[GW-1:0];
                            r_pos   <= r_acc[HW-1:0];
                            r_moves <= '0;
                            r_total <= r_total + 1'b1;
                            r_state <= S_SWEEP;
                        end
                    end else begin
                        r_hout <= r_hin;
                        if (!r_found) begin
                            r_status <= ST_BAD_HANDLE;
                            r_pos    <= '0;
                            r_moves  <= '0;
                            r_slot   <= '0;
                            r_valid  <= 1'b1;
                            r_state  <= S_OUT;
                        end else if (r_kind != KIND_REMOVE) begin
                            r_status <= ST_OK;
                            r_moves  <= '0;
                            r_valid  <= 1'b1;
                            r_state  <= S_OUT;
                        end else begin
                            r_status      <= ST_OK;
                            r_moves       <= r_acc[HW-1:0] - r_pos - 1'b1;
                            r_used[r_hin] <= 1'b0;
                            if (r_slot_size <= SW'(1)) begin
                                r_g     <= {1'b0, r_slot};
                                r_state <= S_GSHIFT;
                            end else begin
                                r_sizes[r_slot] <= r_slot_size - 1'b1;
                                r_state         <= S_SWEEP;
                            end
                        end
                    end
                end
                // close the gap of an emptied group
                S_GSHIFT: begin
                    if (w_gnext < r_total) begin
                        r_keys[r_g[GW-1:0]]  <= w_alu_in.key_a;
                        r_sizes[r_g[GW-1:0]] <= w_alu_in.size;
                        r_g <= w_gnext;
                    end else begin
                        r_total <= r_total - 1'b1;
                        r_i     <= '0;
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (r_i == (HW+1)'(HANDLES)) begin
                        if (w_is_add) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_valid <= 1'b1;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_FINISH: begin
                    r_used[r_h] <= 1'b1;
                    r_valid     <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_handle_out  = r_hout;
    assign o_position    = r_pos;
    assign o_move_count  = r_moves;
    assign o_group_slot  = r_slot;
    assign o_any_entries = (r_total != '0);

    // A pending result keeps the input side closed
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("result pending while input open");

    // Group count never exceeds the table
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= (GW+1)'(GROUPS))
        else $error("group count overflow");

    // A taken result is not shown again
    a_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) |=> !o_valid)
        else $error("result repeated");

endmodule

// ----- sv/ght_alu.sv -----
// Shared group-scan unit: running position adder, range compare, key compare.
// Depends on ght_pkg.
module ght_alu import ght_pkg::*; (
    input  t_alu_in  i_op,
    output t_alu_out o_res
);

    logic [SW-1:0] w_pos_ext;

    // One group step: next start, is pos inside this group, does the key match
    always_comb begin
        w_pos_ext       = {1'b0, i_op.pos};
        o_res.sum       = i_op.acc + i_op.size;
        o_res.in_range  = (w_pos_ext >= i_op.acc) && (w_pos_ext < o_res.sum);
        o_res.key_eq    = (i_op.key_a == i_op.key_b);
    end

endmodule
